// ===== src/psmd_pkg.sv =====
// Shared types and constants of the printer status message deframer.
// Holds the result kinds, delimiter bytes, operation codes and the queue entry type.
// Depends on nothing; the design modules refer to it by scoped names.
package psmd_pkg;

  localparam logic [7:0] CHAR_EOF = 8'h04;
  localparam logic [7:0] CHAR_PCT = 8'h25;
  localparam logic [7:0] CHAR_LBR = 8'h5B;
  localparam logic [7:0] CHAR_RBR = 8'h5D;

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam int RES_MAX   = 3;
  localparam int RES_CNT_W = $clog2(RES_MAX + 1);
  localparam int RES_IDX_W = $clog2(RES_MAX);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W         = 3;
  localparam int REG_IGNORE_TEXT = 0;

  typedef enum logic [2:0] {
    KIND_TEXT     = 3'd0,
    KIND_MSG_BYTE = 3'd1,
    KIND_START    = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_EOF      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]          count;
    logic [RES_MAX-1:0][2:0]       kinds;
    logic [RES_MAX-1:0][7:0]       bytes;
    logic [15:0]                   eof_total;
  } cmd_t;

endpackage

// ===== src/psmd_in_if.sv =====
// Input channel of the deframer: valid/ready handshake with one item per transfer.
// Depends on nothing.
interface psmd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, operation, data_byte, input ready);
  modport sink   (input valid, operation, data_byte, output ready);
endinterface

// ===== src/psmd_out_if.sv =====
// Result channel of the deframer: valid/ready handshake with one result item per transfer.
// Depends on nothing.
interface psmd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] eof_total;
  logic        last;

  modport source (output valid, kind, out_byte, eof_total, last, input ready);
  modport sink   (input valid, kind, out_byte, eof_total, last, output ready);
endinterface

// ===== src/psmd_front.sv =====
// Front end of the deframer: accepts input items, runs the framing parser and EOF counter.
// Each item that yields results becomes one queue entry holding all of them.
// Depends on psmd_pkg and psmd_in_if.
module psmd_front (
  input  logic                clk,
  input  logic                rst_n,
  psmd_in_if.sink             in_ch,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  output logic                ignore_text,
  input  logic                q_full,
  output logic                q_push,
  output psmd_pkg::cmd_t      q_data
);

  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_PCT1   = 3'd1,
    ST_PCT2   = 3'd2,
    ST_MSG    = 3'd3,
    ST_RB     = 3'd4,
    ST_RBPCT  = 3'd5
  } pstate_t;

  pstate_t        state_r, state_nxt;
  logic [15:0]    eof_r, eof_nxt;
  logic           ignore_r, ignore_nxt;
  logic           accept;
  logic [7:0]     c;
  psmd_pkg::cmd_t cmd;

  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & ~q_full;
  assign c           = in_ch.data_byte;
  assign ignore_text = ignore_r;

  always_comb begin
    state_nxt  = state_r;
    eof_nxt    = eof_r;
    ignore_nxt = ignore_r;
    cmd        = '0;
    if (in_ch.operation == psmd_pkg::OP_RESTART) begin
      state_nxt  = ST_NORMAL;
      ignore_nxt = 1'b0;
    end else if (c == psmd_pkg::CHAR_EOF) begin
      eof_nxt      = eof_r + 16'd1;
      cmd.count    = psmd_pkg::RES_CNT_W'(1);
      cmd.kinds[0] = psmd_pkg::KIND_EOF;
    end else if (!ignore_r) begin
      unique case (state_r)
        ST_PCT1: begin
          if (c == psmd_pkg::CHAR_PCT) begin
            state_nxt = ST_PCT2;
          end else begin
            cmd.count    = psmd_pkg::RES_CNT_W'(2);
            cmd.kinds[0] = psmd_pkg::KIND_TEXT;
            cmd.bytes[0] = psmd_pkg::CHAR_PCT;
            cmd.kinds[1] = psmd_pkg::KIND_TEXT;
            cmd.bytes[1] = c;
            state_nxt    = ST_NORMAL;
          end
        end
        ST_PCT2: begin
          if (c == psmd_pkg::CHAR_LBR) begin
            cmd.count    = psmd_pkg::RES_CNT_W'(1);
            cmd.kinds[0] = psmd_pkg::KIND_START;
            state_nxt    = ST_MSG;
          end else begin
            cmd.count    = psmd_pkg::RES_CNT_W'(3);
            cmd.kinds[0] = psmd_pkg::KIND_TEXT;
            cmd.bytes[0] = psmd_pkg::CHAR_PCT;
            cmd.kinds[1] = psmd_pkg::KIND_TEXT;
            cmd.bytes[1] = psmd_pkg::CHAR_PCT;
            cmd.kinds[2] = psmd_pkg::KIND_TEXT;
            cmd.bytes[2] = c;
            state_nxt    = ST_NORMAL;
          end
        end
        ST_MSG: begin
          if (c == psmd_pkg::CHAR_RBR) begin
            state_nxt = ST_RB;
          end else begin
            cmd.count    = psmd_pkg::RES_CNT_W'(1);
            cmd.kinds[0] = psmd_pkg::KIND_MSG_BYTE;
            cmd.bytes[0] = c;
          end
        end
        ST_RB: begin
          if (c == psmd_pkg::CHAR_PCT) begin
            state_nxt = ST_RBPCT;
          end else begin
            cmd.count    = psmd_pkg::RES_CNT_W'(2);
            cmd.kinds[0] = psmd_pkg::KIND_MSG_BYTE;
            cmd.bytes[0] = psmd_pkg::CHAR_RBR;
            cmd.kinds[1] = psmd_pkg::KIND_MSG_BYTE;
            cmd.bytes[1] = c;
            state_nxt    = ST_MSG;
          end
        end
        ST_RBPCT: begin
          if (c == psmd_pkg::CHAR_PCT) begin
            cmd.count    = psmd_pkg::RES_CNT_W'(1);
            cmd.kinds[0] = psmd_pkg::KIND_DONE;
            state_nxt    = ST_NORMAL;
          end else begin
            cmd.count    = psmd_pkg::RES_CNT_W'(3);
            cmd.kinds[0] = psmd_pkg::KIND_MSG_BYTE;
            cmd.bytes[0] = psmd_pkg::CHAR_RBR;
            cmd.kinds[1] = psmd_pkg::KIND_MSG_BYTE;
            cmd.bytes[1] = psmd_pkg::CHAR_PCT;
            cmd.kinds[2] = psmd_pkg::KIND_MSG_BYTE;
            cmd.bytes[2] = c;
            state_nxt    = ST_MSG;
          end
        end
        default: begin
          // The normal state, and the two codes that never arise.
          if (c == psmd_pkg::CHAR_PCT) begin
            state_nxt = ST_PCT1;
          end else begin
            cmd.count    = psmd_pkg::RES_CNT_W'(1);
            cmd.kinds[0] = psmd_pkg::KIND_TEXT;
            cmd.bytes[0] = c;
            state_nxt    = ST_NORMAL;
          end
        end
      endcase
    end
    cmd.eof_total = eof_nxt;
  end

  assign q_push = accept & (cmd.count != '0);
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_NORMAL;
      eof_r    <= '0;
      ignore_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
        eof_r   <= eof_nxt;
      end
      if (cfg_we) begin
        ignore_r <= cfg_wdata;
      end else if (accept) begin
        ignore_r <= ignore_nxt;
      end
    end
  end

endmodule

// ===== src/psmd_queue.sv =====
// Short queue of parsed entries between the front end and the result sequencer.
// Depends on psmd_pkg.
module psmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psmd_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output psmd_pkg::cmd_t head
);

  psmd_pkg::cmd_t                  mem_r [psmd_pkg::QUEUE_DEPTH];
  logic [psmd_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [psmd_pkg::QCNT_W-1:0]     count_r;
  logic                            do_push, do_pop;

  assign full    = (count_r == psmd_pkg::QCNT_W'(psmd_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == psmd_pkg::QPTR_W'(psmd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == psmd_pkg::QPTR_W'(psmd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/psmd_back.sv =====
// Result sequencer of the deframer: plays out each queue entry's results one per cycle
// while not stalled, into a registered output stage. Depends on psmd_pkg, psmd_out_if.
module psmd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  psmd_pkg::cmd_t q_head,
  output logic           q_pop,
  psmd_out_if.source     out_ch
);

  logic [psmd_pkg::RES_IDX_W-1:0] idx_r;
  logic                           out_valid_r;
  logic [2:0]                     kind_r;
  logic [7:0]                     byte_r;
  logic [15:0]                    eof_total_r;
  logic                           last_r;
  logic                           emit;
  logic                           is_last;

  assign emit    = ~q_empty & (~out_valid_r | out_ch.ready);
  assign is_last = (psmd_pkg::RES_CNT_W'(idx_r) == q_head.count - 1'b1);
  assign q_pop   = emit & is_last;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.eof_total = eof_total_r;
  assign out_ch.last      = last_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r      <= q_head.kinds[idx_r];
      byte_r      <= q_head.bytes[idx_r];
      eof_total_r <= q_head.eof_total;
      last_r      <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/printer_status_message_deframer.sv =====
// Printer status message deframer top level: configuration register, front end, queue and
// result sequencer. Depends on psmd_pkg, psmd_in_if, psmd_out_if, psmd_front, psmd_queue
// and psmd_back.
//
// Bytes from a printer's back channel arrive as items on in_ch (operation, data_byte).
// Plain text, message bytes, message start and completion markers and EOF reports leave
// as result items on out_ch; each input gives zero to three results, the final one with
// last set, and every result carries the EOF count after its input.
// An input item is taken in every cycle while the two-entry queue has room. Its results
// pass through a queue entry and then the output register to out_ch, one result per cycle
// while the receiver takes them; new items are taken while earlier ones still play out.
// When the receiver stalls, the output register holds its result, the queue fills and
// in_ch.ready falls after at most two further items that yield results.
// The ignore_text register sits at APB addresses 0 to 3 and reads back its value;
// a restart item also clears it. A synchronous low rst_n empties the queue, returns the
// parser to normal text and clears the EOF count and ignore_text.
module printer_status_message_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  psmd_in_if.sink                      in_ch,
  psmd_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psmd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic           cfg_we;
  logic           cfg_hit;
  logic           ignore_text;
  logic           q_full, q_empty, q_push, q_pop;
  psmd_pkg::cmd_t q_data, q_head;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[psmd_pkg::PADDR_W-1] == 1'(psmd_pkg::REG_IGNORE_TEXT));
  assign cfg_we  = psel & penable & pwrite & cfg_hit;
  assign prdata  = cfg_hit ? {31'd0, ignore_text} : 32'd0;

  psmd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[0]),
    .ignore_text (ignore_text),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  psmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  psmd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
